// File: src/bpb_pkg.sv
// ----------------------------------------------------------------------------
// bpb_pkg
// Types, codes and helpers shared by the bit packet buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpb_pkg;

  // Operation codes carried in the func field of an input item
  typedef enum logic [2:0] {
    FN_CLEAR    = 3'd0,
    FN_APP_BIT  = 3'd1,
    FN_RD_BIT   = 3'd2,
    FN_WR_BIT   = 3'd3,
    FN_FLIP     = 3'd4,
    FN_RD_CHUNK = 3'd5,
    FN_APP_WORD = 3'd6,
    FN_RD_WORD  = 3'd7
  } bpb_func_e;

  // What the result of an operation carries back from the byte window
  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_BIT   = 2'd1,
    RES_CHUNK = 2'd2,
    RES_WORD  = 2'd3
  } bpb_res_e;

  localparam logic [5:0] CHUNK_MAX = 6'd8;
  localparam logic [5:0] WORD_W8   = 6'd8;
  localparam logic [5:0] WORD_W16  = 6'd16;
  localparam logic [5:0] WORD_W32  = 6'd32;

  // Register file: one register, index taken from paddr[2]
  localparam int unsigned BPB_PADDR_W    = 3;
  localparam logic [0:0]  REG_FLIP_LIMIT = 1'b0;

  typedef struct packed {
    bpb_func_e   func;
    logic [9:0]  position;
    logic        bit_value;
    logic [5:0]  field_width;
    logic [31:0] word_value;
  } bpb_in_t;

  typedef struct packed {
    logic        ok;
    logic        bit_out;
    logic [31:0] value_out;
    logic [10:0] next_position;
    logic [10:0] count_out;
  } bpb_out_t;

  // Decoded operation: a span of bits over a window of up to five bytes
  typedef struct packed {
    logic        ok;
    logic        wr;
    logic        flip;
    bpb_res_e    kind;
    logic [2:0]  off;
    logic [2:0]  nbytes;
    logic [5:0]  nbits;
    logic [39:0] mask;
    logic [39:0] data;
    logic [10:0] next_pos;
  } bpb_plan_t;

  function automatic logic [31:0] byte_swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // n ones from the top bit down
  function automatic logic [31:0] lead_ones(input logic [5:0] n);
    logic [31:0] r;
    if (n == 6'd0) begin
      r = '0;
    end else begin
      r = ~32'h0 << (6'd32 - n);
    end
    return r;
  endfunction

  // n ones from bit zero up
  function automatic logic [31:0] low_ones(input logic [5:0] n);
    return ~(~32'h0 << n);
  endfunction

endpackage

`default_nettype wire

// File: src/bpb_ram.sv
// ----------------------------------------------------------------------------
// bpb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/bpb_plan.sv
// ----------------------------------------------------------------------------
// bpb_plan
// Operation decoder: bound checks, new bit count and the bit span to touch.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_plan import bpb_pkg::*; #(
  parameter int unsigned MAX_BYTES = 128
) (
  input  wire bpb_in_t                                  item_i,
  input  wire logic [$clog2(MAX_BYTES*8+1)-1:0]         count_i,
  input  wire logic [10:0]                              flip_limit_i,
  output bpb_plan_t                                     plan_o,
  output logic      [$clog2(MAX_BYTES)-1:0]             start_o,
  output logic      [$clog2(MAX_BYTES*8+1)-1:0]         count_o
);

  localparam int unsigned CapBits = MAX_BYTES * 8;
  localparam int unsigned CntW    = $clog2(CapBits + 1);
  localparam int unsigned AddrW   = $clog2(MAX_BYTES);
  localparam int unsigned SW      = (CntW > 11) ? CntW : 11;

  logic [SW-1:0] cnt_x, pos_x, wid_x, cap_x, end_x, avail, fl_x, s, cnt_new;
  logic [5:0]    n;
  logic [5:0]    span;
  logic [31:0]   src;
  logic          word_ok;

  assign cnt_x = SW'(count_i);
  assign pos_x = SW'(item_i.position);
  assign wid_x = SW'(item_i.field_width);
  assign cap_x = SW'(CapBits);
  assign fl_x  = SW'(flip_limit_i);
  assign end_x = pos_x + wid_x;
  assign avail = cap_x - cnt_x;

  assign word_ok = item_i.field_width inside {WORD_W8, WORD_W16, WORD_W32};

  always_comb begin
    plan_o          = '0;
    plan_o.kind     = RES_NONE;
    s               = pos_x;
    n               = '0;
    src             = '0;
    cnt_new         = cnt_x;
    case (item_i.func)
      FN_CLEAR: begin
        // store contents beyond the count are never read, so only the count drops
        plan_o.ok = 1'b1;
        cnt_new   = '0;
      end
      FN_APP_BIT: begin
        if (cnt_x < cap_x) begin
          plan_o.ok = 1'b1;
          plan_o.wr = 1'b1;
          s         = cnt_x;
          n         = 6'd1;
          src       = {item_i.bit_value, 31'h0};
          cnt_new   = cnt_x + SW'(1);
        end
      end
      FN_RD_BIT: begin
        if (pos_x < cnt_x) begin
          plan_o.ok   = 1'b1;
          plan_o.kind = RES_BIT;
          n           = 6'd1;
        end
      end
      FN_WR_BIT: begin
        if (pos_x < cap_x) begin
          plan_o.ok = 1'b1;
          plan_o.wr = 1'b1;
          n         = 6'd1;
          src       = {item_i.bit_value, 31'h0};
        end
      end
      FN_FLIP: begin
        if (pos_x < fl_x && pos_x < cap_x) begin
          plan_o.ok   = 1'b1;
          plan_o.wr   = 1'b1;
          plan_o.flip = 1'b1;
          n           = 6'd1;
        end
      end
      FN_RD_CHUNK: begin
        plan_o.next_pos = 11'(pos_x);
        if (item_i.field_width <= CHUNK_MAX && end_x <= cnt_x) begin
          plan_o.ok       = 1'b1;
          plan_o.kind     = RES_CHUNK;
          n               = item_i.field_width;
          plan_o.next_pos = end_x[10:0];
        end
      end
      FN_APP_WORD: begin
        if (word_ok) begin
          plan_o.wr = 1'b1;
          s         = cnt_x;
          src       = byte_swap32(item_i.word_value);
          // stop at capacity, keeping the bits that fit
          if (avail >= wid_x) begin
            plan_o.ok = 1'b1;
            n         = item_i.field_width;
          end else begin
            n = avail[5:0];
          end
          cnt_new = cnt_x + SW'(n);
        end
      end
      FN_RD_WORD: begin
        plan_o.next_pos = 11'(pos_x);
        if (word_ok && end_x <= cnt_x) begin
          plan_o.ok       = 1'b1;
          plan_o.kind     = RES_WORD;
          n               = item_i.field_width;
          plan_o.next_pos = end_x[10:0];
        end
      end
      default: begin
        plan_o.ok = 1'b0;
      end
    endcase

    span           = 6'(s[2:0]) + n - 6'd1;
    plan_o.off     = s[2:0];
    plan_o.nbits   = n;
    plan_o.nbytes  = (n == 6'd0) ? 3'd0 : (span[5:3] + 3'd1);
    plan_o.mask    = {lead_ones(n), 8'h00} >> s[2:0];
    plan_o.data    = {src, 8'h00} >> s[2:0];
  end

  assign start_o = s[AddrW+2:3];
  assign count_o = cnt_new[CntW-1:0];

endmodule

`default_nettype wire

// File: src/bpb_seq.sv
// ----------------------------------------------------------------------------
// bpb_seq
// Byte sequencer: walks the bytes of one operation through the byte RAM,
// merging and writing each byte back the cycle its read data returns.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_seq import bpb_pkg::*; #(
  parameter int unsigned MAX_BYTES = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire bpb_in_t     in_item_i,
  input  wire logic [10:0] flip_limit_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output bpb_out_t         res_o
);

  localparam int unsigned CapBits = MAX_BYTES * 8;
  localparam int unsigned CntW    = $clog2(CapBits + 1);
  localparam int unsigned AddrW   = $clog2(MAX_BYTES);
  localparam int unsigned CntX    = (CntW > 11) ? CntW : 11;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PLAN = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } bpb_state_e;

  bpb_state_e       state_q, state_d;
  bpb_in_t          item_q;
  bpb_plan_t        plan_q, plan_d;
  logic [AddrW-1:0] start_q, start_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [2:0]       rd_cnt_q;
  logic             rvalid_q;
  logic [2:0]       ridx_q;
  logic [7:0]       win_q [5];

  logic             ram_re, ram_we;
  logic [AddrW-1:0] ram_raddr, ram_waddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [39:0]      mask_sh, data_sh, win_flat, win_sh;
  logic [7:0]       mk, dk;
  logic             last_byte;
  logic [CntX-1:0]  count_x;

  bpb_plan #(.MAX_BYTES(MAX_BYTES)) u_plan (
    .item_i       (item_q),
    .count_i      (count_q),
    .flip_limit_i (flip_limit_i),
    .plan_o       (plan_d),
    .start_o      (start_d),
    .count_o      (count_d)
  );

  bpb_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // read side: one byte address per cycle
  assign ram_re    = (state_q == ST_RUN) && (rd_cnt_q < plan_q.nbytes);
  assign ram_raddr = start_q + AddrW'(rd_cnt_q);

  // write side: merge the byte that has just come back
  assign mask_sh   = plan_q.mask << {ridx_q, 3'b000};
  assign data_sh   = plan_q.data << {ridx_q, 3'b000};
  assign mk        = mask_sh[39:32];
  assign dk        = data_sh[39:32];
  assign ram_wdata = plan_q.flip ? (ram_rdata ^ mk) : ((ram_rdata & ~mk) | (dk & mk));
  assign ram_we    = rvalid_q && plan_q.wr;
  assign ram_waddr = start_q + AddrW'(ridx_q);
  assign last_byte = rvalid_q && (ridx_q == plan_q.nbytes - 3'd1);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        state_d = (plan_d.nbytes != 3'd0) ? ST_RUN : ST_DONE;
      end
      ST_RUN: begin
        if (last_byte) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_cnt_q <= '0;
      rvalid_q <= 1'b0;
      ridx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PLAN) begin
        count_q  <= count_d;
        rd_cnt_q <= '0;
        rvalid_q <= 1'b0;
      end else if (state_q == ST_RUN) begin
        rvalid_q <= ram_re;
        ridx_q   <= rd_cnt_q;
        if (ram_re) begin
          rd_cnt_q <= rd_cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    if (state_q == ST_PLAN) begin
      plan_q  <= plan_d;
      start_q <= start_d;
    end
    if (rvalid_q) begin
      win_q[ridx_q] <= ram_rdata;
    end
  end

  // result: align the window so the first bit of the span sits on top
  assign win_flat = {win_q[0], win_q[1], win_q[2], win_q[3], win_q[4]};
  assign win_sh   = win_flat << plan_q.off;
  assign count_x  = CntX'(count_q);

  always_comb begin
    res_o               = '0;
    res_o.ok            = plan_q.ok;
    res_o.next_position = plan_q.next_pos;
    res_o.count_out     = count_x[10:0];
    case (plan_q.kind)
      RES_BIT: begin
        res_o.bit_out = win_sh[39];
      end
      RES_CHUNK: begin
        res_o.value_out = 32'(win_sh[39:32] >> (4'd8 - plan_q.nbits[3:0]));
      end
      RES_WORD: begin
        res_o.value_out = byte_swap32(win_sh[39:8]) & low_ones(plan_q.nbits);
      end
      default: begin
        res_o.value_out = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/bit_packet_buffer_core.sv
// An accepted item passes the sequencer states PLAN, RUN and DONE, then the output
//   register; RUN walks the nb bytes of the store the operation spans (1..5) and is
//   skipped when no byte is touched (clear, a failed bound check other than a partly
//   fitting word append, a zero-length chunk). RUN reads the single byte RAM one byte
//   address per cycle, and a new item is taken once the result leaves the sequencer.
// Reset: bit count and flip_limit go to zero at once; the store is not swept, since
//   the bit count acts as fill mark and no bit at or beyond it is ever read.
// ----------------------------------------------------------------------------
// bit_packet_buffer_core
// Bit-addressable packet store with APB register port and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_packet_buffer_core import bpb_pkg::*; #(
  parameter int unsigned MAX_BYTES = 128
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire bpb_in_t                in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output bpb_out_t                    out_item_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [BPB_PADDR_W-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  logic [10:0] flip_limit_q;
  logic        out_valid_q;
  bpb_out_t    out_item_q;
  logic        res_valid, res_ready;
  bpb_out_t    res;
  logic        reg_sel;

  assign reg_sel = (paddr[BPB_PADDR_W-1:2] == REG_FLIP_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {21'h0, flip_limit_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_limit_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      flip_limit_q <= pwdata[10:0];
    end
  end

  bpb_seq #(.MAX_BYTES(MAX_BYTES)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .flip_limit_i (flip_limit_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // hold the result until taken; refill in the cycle it leaves
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: src/bpb_checker.sv
// ----------------------------------------------------------------------------
// bpb_checker
// Port-level checks for the bit packet buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_checker import bpb_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire bpb_out_t               out_item_o,
  input wire logic                   psel,
  input wire logic                   penable,
  input wire logic                   pwrite,
  input wire logic [BPB_PADDR_W-1:0] paddr,
  input wire logic [31:0]            pwdata,
  input wire logic [31:0]            prdata,
  input wire logic                   pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while the previous one is still at work");

  // a failed operation returns no data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.ok |-> !out_item_o.bit_out && out_item_o.value_out == 32'h0)
    else $error("failed operation returned data");

  // a register write reads back
  a_cfg_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[BPB_PADDR_W-1:2] == REG_FLIP_LIMIT
    |=> paddr[BPB_PADDR_W-1:2] != REG_FLIP_LIMIT || prdata[10:0] == $past(pwdata[10:0]))
    else $error("flip_limit read back differs from the value written");

endmodule

bind bit_packet_buffer_core bpb_checker u_bpb_checker (.*);

`default_nettype wire

// File: verif/tb_bit_packet_buffer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bit_packet_buffer_core
// Self-checking bench for the bit packet buffer: a directed table, then random
// operation streams with fill-to-capacity bursts, across several flip_limit
// settings and idling patterns. Each result is checked against its table row or a local model.
// ----------------------------------------------------------------------------
module tb_bit_packet_buffer_core;
  import bpb_pkg::*;

  localparam int unsigned PKT_BYTES      = 128;
  localparam int unsigned CAP_BITS       = PKT_BYTES * 8;
  localparam int          OPS_PER_PHASE  = 230;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 16;
  localparam logic [BPB_PADDR_W-1:0] FLIP_LIMIT_ADDR = {REG_FLIP_LIMIT, 2'b00};

  typedef struct {
    bpb_in_t  item;
    int       lim;   // flip_limit to set before the item, or -1
    bit       chk;
    bpb_out_t want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  bpb_in_t                in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  bpb_out_t               out_item;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [BPB_PADDR_W-1:0] paddr     = '0;
  logic [31:0]            pwdata    = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // local copy of the packet store
  logic [7:0]  pkt_mem [PKT_BYTES];
  int unsigned fill_bits = 0;
  int unsigned flip_lim  = 0;

  bpb_out_t pending_results [$];
  dir_row_t dir_tab [$];
  int       mismatches   = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  int       tx_idle_pct  = 0;
  int       rx_stall_pct = 0;

  bit_packet_buffer_core #(.MAX_BYTES(PKT_BYTES)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    foreach (pkt_mem[k]) pkt_mem[k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input int idx, input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0h want %0h", idx, name, got, want));
    end
  endtask

  function automatic bit pkt_bit(input int unsigned p);
    return (p < CAP_BITS) ? pkt_mem[p >> 3][7 - (p & 7)] : 1'b0;
  endfunction

  function automatic void put_pkt_bit(input int unsigned p, input bit v);
    if (p < CAP_BITS) pkt_mem[p >> 3][7 - (p & 7)] = v;
  endfunction

  // word bit i in stream order: low byte first, MSB first within a byte
  function automatic int unsigned stream_bit_index(input int unsigned i);
    return 8 * (i >> 3) + 7 - (i & 7);
  endfunction

  function automatic bpb_out_t predict_packet_op(input bpb_in_t it);
    bpb_out_t    r;
    int unsigned pos, w, nxt, i;
    bit          word_w_ok;
    r         = '0;
    pos       = 32'(it.position);
    w         = 32'(it.field_width);
    nxt       = 0;
    word_w_ok = (w == 8) || (w == 16) || (w == 32);
    case (it.func)
      FN_CLEAR: begin
        foreach (pkt_mem[k]) pkt_mem[k] = '0;
        fill_bits = 0;
        r.ok      = 1'b1;
      end
      FN_APP_BIT: begin
        if (fill_bits < CAP_BITS) begin
          put_pkt_bit(fill_bits, it.bit_value);
          fill_bits++;
          r.ok = 1'b1;
        end
      end
      FN_RD_BIT: begin
        if (pos < fill_bits) begin
          r.bit_out = pkt_bit(pos);
          r.ok      = 1'b1;
        end
      end
      FN_WR_BIT: begin
        if (pos < CAP_BITS) begin
          put_pkt_bit(pos, it.bit_value);
          r.ok = 1'b1;
        end
      end
      FN_FLIP: begin
        if (pos < flip_lim && pos < CAP_BITS) begin
          put_pkt_bit(pos, !pkt_bit(pos));
          r.ok = 1'b1;
        end
      end
      FN_RD_CHUNK: begin
        nxt = pos;
        if (w <= 8 && pos + w <= fill_bits) begin
          for (i = 0; i < w; i++) r.value_out = {r.value_out[30:0], pkt_bit(pos + i)};
          nxt  = pos + w;
          r.ok = 1'b1;
        end
      end
      FN_APP_WORD: begin
        if (word_w_ok) begin
          r.ok = 1'b1;
          // stop at capacity, keeping the bits already appended
          for (i = 0; i < w && r.ok; i++) begin
            if (fill_bits >= CAP_BITS) begin
              r.ok = 1'b0;
            end else begin
              put_pkt_bit(fill_bits, it.word_value[stream_bit_index(i)]);
              fill_bits++;
            end
          end
        end
      end
      default: begin
        nxt = pos;
        if (word_w_ok && pos + w <= fill_bits) begin
          for (i = 0; i < w; i++) r.value_out[stream_bit_index(i)] = pkt_bit(pos + i);
          nxt  = pos + w;
          r.ok = 1'b1;
        end
      end
    endcase
    r.next_position = nxt[10:0];
    r.count_out     = fill_bits[10:0];
    return r;
  endfunction

  function automatic bpb_in_t mk_item(input bpb_func_e f, input int pos, input int bv,
                                      input int w, input logic [31:0] word);
    bpb_in_t it;
    it.func        = f;
    it.position    = pos[9:0];
    it.bit_value   = bv[0];
    it.field_width = w[5:0];
    it.word_value  = word;
    return it;
  endfunction

  function automatic dir_row_t mk_row(input int lim, input bpb_func_e f, input int pos,
                                      input int bv, input int w, input logic [31:0] word,
                                      input int chk, input int ok, input int bo,
                                      input logic [31:0] val, input int nxt, input int cnt);
    dir_row_t row;
    row.item               = mk_item(f, pos, bv, w, word);
    row.lim                = lim;
    row.chk                = chk[0];
    row.want.ok            = ok[0];
    row.want.bit_out       = bo[0];
    row.want.value_out     = val;
    row.want.next_position = nxt[10:0];
    row.want.count_out     = cnt[10:0];
    return row;
  endfunction

  // position around the fill mark, the flip limit, or anywhere
  function automatic int near_fill(input int span);
    int c, p;
    c = fill_bits;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: p = (c > span) ? int'($urandom_range(c - span)) : 0;
      6, 7:             p = c - span + int'($urandom_range(4)) - 2;
      8:                p = int'(flip_lim) + int'($urandom_range(2)) - 1;
      default:          p = $urandom_range(1023);
    endcase
    if (p < 0) p = 0;
    if (p > 1023) p = 1023;
    return p;
  endfunction

  function automatic int word_width();
    int w;
    case ($urandom_range(9))
      0:       w = $urandom_range(63);
      1, 2, 3: w = 8;
      4, 5, 6: w = 16;
      default: w = 32;
    endcase
    return w;
  endfunction

  function automatic bpb_in_t random_packet_op();
    bpb_in_t it;
    int      r;
    it = mk_item(FN_CLEAR, $urandom_range(1023), $urandom_range(1), $urandom_range(63),
                 $urandom);
    r  = $urandom_range(99);
    if (r < 2)       it.func = FN_CLEAR;
    else if (r < 17) it.func = FN_APP_BIT;
    else if (r < 30) it.func = FN_APP_WORD;
    else if (r < 44) it.func = FN_RD_BIT;
    else if (r < 52) it.func = FN_WR_BIT;
    else if (r < 62) it.func = FN_FLIP;
    else if (r < 80) it.func = FN_RD_CHUNK;
    else             it.func = FN_RD_WORD;
    case (it.func)
      FN_RD_CHUNK: begin
        it.field_width = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(8));
        it.position    = 10'(near_fill(int'(it.field_width)));
      end
      FN_APP_WORD: it.field_width = 6'(word_width());
      FN_RD_WORD: begin
        it.field_width = 6'(word_width());
        it.position    = 10'(near_fill(int'(it.field_width)));
      end
      FN_RD_BIT, FN_WR_BIT, FN_FLIP: begin
        if ($urandom_range(1)) it.position = 10'(near_fill(1));
      end
      default: ;
    endcase
    return it;
  endfunction

  // present one item, hold it until accepted, then record its expected result
  task automatic issue_op(input bpb_in_t it, input bit chk, input bpb_out_t typed);
    bpb_out_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    want = predict_packet_op(it);
    pending_results.push_back(chk ? typed : want);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FLIP_LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_flip_limit(input int unsigned lim);
    logic [31:0] rd;
    wait_results_drained();
    apb_access(1'b1, lim, rd);
    flip_lim = lim;
    apb_access(1'b0, '0, rd);
    check_field(results_seen, "flip_limit readback", rd, lim);
  endtask

  // fill the store, cross capacity, then poke around the top end
  task automatic burst_to_capacity(inout int sent);
    while (fill_bits + 40 < CAP_BITS) begin
      issue_op(mk_item(FN_APP_WORD, 0, 0, 32, $urandom), 1'b0, '0);
      sent++;
    end
    while (fill_bits < CAP_BITS) begin
      issue_op(mk_item(FN_APP_WORD, 0, 0, word_width(), $urandom), 1'b0, '0);
      sent++;
    end
    issue_op(mk_item(FN_APP_BIT, 0, 1, 0, 0), 1'b0, '0);
    issue_op(mk_item(FN_APP_WORD, 0, 0, 8, $urandom), 1'b0, '0);
    issue_op(mk_item(FN_WR_BIT, 1023, $urandom_range(1), 0, 0), 1'b0, '0);
    issue_op(mk_item(FN_RD_BIT, 1023, 0, 0, 0), 1'b0, '0);
    issue_op(mk_item(FN_RD_CHUNK, 1016, 0, 8, 0), 1'b0, '0);
    issue_op(mk_item(FN_RD_WORD, 992, 0, 32, 0), 1'b0, '0);
    issue_op(mk_item(FN_FLIP, 1023, 0, 0, 0), 1'b0, '0);
    issue_op(mk_item(FN_RD_WORD, 1000, 0, 32, 0), 1'b0, '0);
    sent += 8;
  endtask

  always @(posedge clk) begin : result_monitor
    bpb_out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with no item pending", results_seen));
        end else begin
          want = pending_results.pop_front();
          check_field(results_seen, "ok", 32'(out_item.ok), 32'(want.ok));
          check_field(results_seen, "bit_out", 32'(out_item.bit_out), 32'(want.bit_out));
          check_field(results_seen, "value_out", out_item.value_out, want.value_out);
          check_field(results_seen, "next_position", 32'(out_item.next_position),
                      32'(want.next_position));
          check_field(results_seen, "count_out", 32'(out_item.count_out),
                      32'(want.count_out));
        end
        results_seen++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int ph, sent;
    int lim_plan [8];
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    //                     lim  func         pos  bv  w   word         chk ok bo val  nxt cnt
    dir_tab.push_back(mk_row(-1, FN_RD_BIT,     0, 0,  0, 32'h0,        1, 0, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_RD_CHUNK,   0, 0,  0, 32'h0,        1, 1, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_RD_CHUNK,   1, 0,  0, 32'h0,        1, 0, 0, 32'h0,  1,  0));
    dir_tab.push_back(mk_row(-1, FN_FLIP,       0, 0,  0, 32'h0,        1, 0, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_APP_WORD,   0, 0, 32, 32'hA5C30F81, 1, 1, 0, 32'h0,  0, 32));
    dir_tab.push_back(mk_row(-1, FN_RD_WORD,    0, 0, 32, 32'h0,        0, 0, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_APP_BIT,    0, 1,  0, 32'h0,        1, 1, 0, 32'h0,  0, 33));
    dir_tab.push_back(mk_row(-1, FN_APP_BIT,    0, 0,  0, 32'h0,        1, 1, 0, 32'h0,  0, 34));
    dir_tab.push_back(mk_row(-1, FN_RD_BIT,    32, 0,  0, 32'h0,        0, 0, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_WR_BIT,  1023, 1,  0, 32'h0,        1, 1, 0, 32'h0,  0, 34));
    dir_tab.push_back(mk_row(-1, FN_RD_BIT,  1023, 0,  0, 32'h0,        1, 0, 0, 32'h0,  0, 34));
    dir_tab.push_back(mk_row(-1, FN_RD_CHUNK,  26, 0,  8, 32'h0,        0, 0, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_RD_CHUNK,   0, 0,  9, 32'h0,        1, 0, 0, 32'h0,  0, 34));
    dir_tab.push_back(mk_row(-1, FN_RD_CHUNK,  30, 0,  5, 32'h0,        1, 0, 0, 32'h0, 30, 34));
    dir_tab.push_back(mk_row(-1, FN_APP_WORD,   0, 0,  7, 32'hFFFFFFFF, 1, 0, 0, 32'h0,  0, 34));
    dir_tab.push_back(mk_row(-1, FN_RD_WORD,    0, 0, 24, 32'h0,        1, 0, 0, 32'h0,  0, 34));
    dir_tab.push_back(mk_row(-1, FN_APP_WORD,   0, 0,  8, 32'h000000FF, 1, 1, 0, 32'h0,  0, 42));
    dir_tab.push_back(mk_row(-1, FN_APP_WORD,   0, 0, 16, 32'hFFFF1234, 1, 1, 0, 32'h0,  0, 58));
    dir_tab.push_back(mk_row(-1, FN_RD_WORD,   34, 0, 16, 32'h0,        0, 0, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_RD_WORD,   27, 0, 32, 32'h0,        1, 0, 0, 32'h0, 27, 58));
    dir_tab.push_back(mk_row(1024, FN_FLIP,  1023, 0,  0, 32'h0,        1, 1, 0, 32'h0,  0, 58));
    dir_tab.push_back(mk_row(-1, FN_FLIP,       5, 0,  0, 32'h0,        1, 1, 0, 32'h0,  0, 58));
    dir_tab.push_back(mk_row(-1, FN_RD_WORD,    0, 0, 32, 32'h0,        0, 0, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_CLEAR,      0, 0,  0, 32'h0,        1, 1, 0, 32'h0,  0,  0));
    dir_tab.push_back(mk_row(-1, FN_RD_BIT,     0, 0,  0, 32'h0,        1, 0, 0, 32'h0,  0,  0));

    foreach (dir_tab[n]) begin
      if (dir_tab[n].lim >= 0) set_flip_limit(dir_tab[n].lim);
      issue_op(dir_tab[n].item, dir_tab[n].chk, dir_tab[n].want);
    end

    lim_plan    = '{1024, 0, 1, 1023, 512, 0, 1024, 0};
    lim_plan[5] = $urandom_range(1024);
    lim_plan[7] = $urandom_range(1024);
    for (ph = 0; ph < 8; ph++) begin
      set_flip_limit(lim_plan[ph]);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      sent = 0;
      while (sent < OPS_PER_PHASE) begin
        if ((ph == 0 && sent == 0) || $urandom_range(999) < 8) begin
          burst_to_capacity(sent);
        end else begin
          issue_op(random_packet_op(), 1'b0, '0);
          sent++;
        end
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bpb_pkg.sv
src/bpb_ram.sv
src/bpb_plan.sv
src/bpb_seq.sv
src/bit_packet_buffer_core.sv
src/bpb_checker.sv
verif/tb_bit_packet_buffer_core.sv
